// ===== rtl/ptc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

	// one sample pair
	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	// one compensated result
	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               pressure_valid;
	} result_t;

	// register index on the configuration port
	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_TEMP_CAL   = 3'd0;
	localparam cfg_index_t CFG_PRESS_LOW  = 3'd1;
	localparam cfg_index_t CFG_PRESS_HIGH = 3'd2;
	localparam cfg_index_t CFG_PRESS_P9   = 3'd3;

	// compensation constants
	localparam int unsigned DIV_STEPS   = 64;
	localparam logic [20:0] ADC_FULL    = 21'd1048576;
	localparam int          FINE_OFFSET = 128000;
	localparam logic [63:0] ONE_AT_47   = 64'h0000_8000_0000_0000;
	localparam logic [63:0] SCALE_3125  = 64'd3125;

endpackage

`default_nettype wire

// ===== rtl/pressure_temperature_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Barometric sensor compensation: each transaction on the sample channel carries a raw
// temperature and a raw pressure conversion and yields one result transaction with the
// temperature in hundredths of a degree (saturated) and the pressure in pascal times 256
// (clamped, flagged invalid when clamped or when the divisor is zero). The pipeline
// takes one sample per cycle while the result channel does not stall, and 64 quotient
// stages carry out the pressure division, one quotient bit per stage. A stall on the
// result channel holds the whole pipeline, and sample_stall follows it. Calibration
// registers are written through the cfg channel, which is always ready; the user is to
// write them only while the block is idle, which the block itself does not enforce.
module pressure_temperature_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  ptc_pkg::sample_t    sample,
	output logic                result_valid,
	input  logic                result_stall,
	output ptc_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  ptc_pkg::cfg_index_t cfg_index,
	input  logic [63:0]         cfg_data
);
	import ptc_pkg::*;

	// divider stage contents
	typedef struct packed {
		logic [30:0]        rem;
		logic [63:0]        qt;
		logic [30:0]        mb;
		logic               neg;
		logic               zero;
		logic signed [15:0] temp;
	} div_t;

	logic [47:0] temp_cal_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_p9_q;

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	logic en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [DIV_STEPS:0] dvv_s;
	logic v_s11, v_s12, v_s13;

	// payload registers
	logic signed [17:0] x1_s1;
	logic signed [16:0] d_s1;
	logic [20:0]        pp_s1, pp_s2, pp_s3, pp_s4, pp_s5, pp_s6, pp_s7, pp_s8;
	logic signed [33:0] ta_s2;
	logic [31:0]        dd_s2;
	logic signed [22:0] ta_s3;
	logic signed [36:0] tb_s3;
	logic signed [31:0] fine_s4;
	logic signed [15:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [31:0] pa_s5;
	logic [63:0]        aa_s6;
	logic signed [47:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7;
	logic signed [63:0] b6_s7, a3_s7;
	logic signed [63:0] bsum_s8, asum_s8;
	logic signed [30:0] dvs_s9;
	logic [63:0]        num_s9;
	div_t               dv_s [DIV_STEPS+1];
	logic [63:0]        pq_s11, pq_s12, pq_s13;
	logic signed [50:0] x_s11;
	logic [63:0]        m1_s11;
	logic signed [44:0] e_s11, e_s12, e_s13;
	logic               zero_s11, zero_s12, zero_s13;
	logic signed [15:0] temp_s11, temp_s12, temp_s13;
	logic [63:0]        pp0_s12;
	logic [31:0]        pp1_s12, pp2_s12;
	logic signed [38:0] c_s13;

	// combinational stage values
	logic signed [17:0] x1_c;
	logic signed [16:0] d_c;
	logic signed [33:0] dd_full_c;
	logic signed [31:0] t5_c, tc_c;
	logic signed [15:0] tsat_c;
	logic signed [63:0] b6_c, a3_c;
	logic signed [63:0] dvprod_c;
	logic [63:0]        num_c;
	logic [30:0]        mb_c;
	logic [63:0]        q_c;
	logic signed [63:0] e_full_c, m1_c, x64_c;
	logic [63:0]        cprod_c, psum_c, pres_c;
	result_t            res_c;

	// calibration fields
	assign t1 = temp_cal_q[15:0];
	assign t2 = temp_cal_q[31:16];
	assign t3 = temp_cal_q[47:32];
	assign p1 = press_low_q[15:0];
	assign p2 = press_low_q[31:16];
	assign p3 = press_low_q[47:32];
	assign p4 = press_low_q[63:48];
	assign p5 = press_high_q[15:0];
	assign p6 = press_high_q[31:16];
	assign p7 = press_high_q[47:32];
	assign p8 = press_high_q[63:48];
	assign p9 = press_p9_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q   <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			press_p9_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TEMP_CAL:   temp_cal_q   <= cfg_data[47:0];
				CFG_PRESS_LOW:  press_low_q  <= cfg_data;
				CFG_PRESS_HIGH: press_high_q <= cfg_data;
				CFG_PRESS_P9:   press_p9_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the result is held
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			dvv_s        <= '0;
			{v_s11, v_s12, v_s13} <= '0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s1         <= sample_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			v_s5         <= v_s4;
			v_s6         <= v_s5;
			v_s7         <= v_s6;
			v_s8         <= v_s7;
			v_s9         <= v_s8;
			dvv_s        <= {dvv_s[DIV_STEPS-1:0], v_s9};
			v_s11        <= dvv_s[DIV_STEPS];
			v_s12        <= v_s11;
			v_s13        <= v_s12;
			result_valid <= v_s13;
		end
	end

	// fine temperature front end
	always_comb begin
		x1_c = $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
		d_c  = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, t1});
		dd_full_c = 34'(d_s1) * 34'(d_s1);
	end

	// temperature scaling and saturation
	always_comb begin
		t5_c = fine_s4 * 32'sd5 + 32'sd128;
		tc_c = t5_c >>> 8;
		if (tc_c > 32'sd32767) begin
			tsat_c = 16'sh7fff;
		end else if (tc_c < -32'sd32768) begin
			tsat_c = 16'sh8000;
		end else begin
			tsat_c = tc_c[15:0];
		end
	end

	// pressure polynomial terms
	always_comb begin
		b6_c     = $signed(aa_s6) * 64'(p6);
		a3_c     = $signed(aa_s6) * 64'(p3);
		dvprod_c = ($signed(ONE_AT_47) + asum_s8) * 64'($signed({1'b0, p1}));
		num_c    = (64'({pp_s8, 31'b0}) - $signed(bsum_s8)) * SCALE_3125;
		mb_c     = dvs_s9[30] ? (31'd0 - dvs_s9) : dvs_s9;
	end

	// front stages
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1   <= x1_c;
			d_s1    <= d_c;
			pp_s1   <= ADC_FULL - {1'b0, sample.raw_pressure};
			ta_s2   <= 34'(x1_s1) * 34'(t2);
			dd_s2   <= dd_full_c[31:0];
			pp_s2   <= pp_s1;
			ta_s3   <= 23'(ta_s2 >>> 11);
			tb_s3   <= 37'($signed({1'b0, dd_s2[31:12]})) * 37'(t3);
			pp_s3   <= pp_s2;
			fine_s4 <= 32'(ta_s3) + 32'(tb_s3 >>> 14);
			pp_s4   <= pp_s3;
			temp_s5 <= tsat_c;
			pa_s5   <= fine_s4 - 32'(FINE_OFFSET);
			pp_s5   <= pp_s4;
			aa_s6   <= 64'(pa_s5) * 64'(pa_s5);
			ap5_s6  <= 48'(pa_s5) * 48'(p5);
			ap2_s6  <= 48'(pa_s5) * 48'(p2);
			temp_s6 <= temp_s5;
			pp_s6   <= pp_s5;
			b6_s7   <= b6_c;
			a3_s7   <= a3_c;
			ap5_s7  <= ap5_s6;
			ap2_s7  <= ap2_s6;
			temp_s7 <= temp_s6;
			pp_s7   <= pp_s6;
			bsum_s8 <= b6_s7 + (64'(ap5_s7) <<< 17) + (64'(p4) <<< 35);
			asum_s8 <= (a3_s7 >>> 8) + (64'(ap2_s7) <<< 12);
			temp_s8 <= temp_s7;
			pp_s8   <= pp_s7;
			dvs_s9  <= dvprod_c[63:33];
			num_s9  <= num_c;
			temp_s9 <= temp_s8;
		end
	end

	// one quotient bit per stage
	function automatic div_t div_step(input div_t d);
		logic [31:0] trial;
		logic        ge;
		div_t        r;
		trial = {d.rem, d.qt[63]};
		ge    = (trial >= {1'b0, d.mb});
		r     = d;
		r.rem = ge ? 31'(trial - {1'b0, d.mb}) : trial[30:0];
		r.qt  = {d.qt[62:0], ge};
		return r;
	endfunction

	// divider entry with sign and magnitude, then the quotient stages
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].rem  <= '0;
			dv_s[0].qt   <= num_s9[63] ? (64'd0 - num_s9) : num_s9;
			dv_s[0].mb   <= mb_c;
			dv_s[0].neg  <= num_s9[63] ^ dvs_s9[30];
			dv_s[0].zero <= (dvs_s9 == '0);
			dv_s[0].temp <= temp_s9;
			for (int k = 0; k < DIV_STEPS; k++) begin
				dv_s[k+1] <= div_step(dv_s[k]);
			end
		end
	end

	// quotient and correction terms
	always_comb begin
		q_c      = dv_s[DIV_STEPS].neg ? (64'd0 - dv_s[DIV_STEPS].qt) : dv_s[DIV_STEPS].qt;
		e_full_c = 64'(p8) * $signed(q_c);
		m1_c     = 64'(p9) * 64'($signed(q_c[63:13]));
		x64_c    = 64'(x_s11);
		cprod_c  = pp0_s12 + {pp1_s12 + pp2_s12, 32'b0};
	end

	// back stages
	always_ff @(posedge clk) begin
		if (en) begin
			pq_s11   <= q_c;
			x_s11    <= q_c[63:13];
			m1_s11   <= m1_c;
			e_s11    <= e_full_c[63:19];
			zero_s11 <= dv_s[DIV_STEPS].zero;
			temp_s11 <= dv_s[DIV_STEPS].temp;
			pp0_s12  <= 64'(m1_s11[31:0]) * 64'(x64_c[31:0]);
			pp1_s12  <= 32'(m1_s11[31:0] * x64_c[63:32]);
			pp2_s12  <= 32'(m1_s11[63:32] * x64_c[31:0]);
			pq_s12   <= pq_s11;
			e_s12    <= e_s11;
			zero_s12 <= zero_s11;
			temp_s12 <= temp_s11;
			c_s13    <= cprod_c[63:25];
			pq_s13   <= pq_s12;
			e_s13    <= e_s12;
			zero_s13 <= zero_s12;
			temp_s13 <= temp_s12;
		end
	end

	// final sum and clamping
	always_comb begin
		psum_c = pq_s13 + 64'(c_s13) + 64'(e_s13);
		pres_c = {{8{psum_c[63]}}, psum_c[63:8]} + (64'(p7) << 4);
		res_c.temperature_centi = temp_s13;
		priority if (zero_s13 || pres_c[63]) begin
			res_c.pressure_q24_8 = '0;
			res_c.pressure_valid = 1'b0;
		end else if (pres_c[62:32] != '0) begin
			res_c.pressure_q24_8 = '1;
			res_c.pressure_valid = 1'b0;
		end else begin
			res_c.pressure_q24_8 = pres_c[31:0];
			res_c.pressure_valid = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			result <= res_c;
		end
	end

`ifndef ASSERT_OFF
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("sample stalled while result channel free");
	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> ($stable(dvv_s) && $stable(v_s13)))
		else $error("pipeline moved while result held");
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(dvv_s[DIV_STEPS] && !dv_s[DIV_STEPS].zero) |->
		(dv_s[DIV_STEPS].rem < dv_s[DIV_STEPS].mb))
		else $error("division remainder not below divisor");
	a_clamp_codes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.pressure_valid) |->
		(result.pressure_q24_8 == 32'd0 || result.pressure_q24_8 == 32'hffff_ffff))
		else $error("invalid pressure not clamped");
`endif

endmodule

`default_nettype wire
